### rtl/core/ksnn_pkg.sv
// ksnn_pkg: codes, constants and small lookup functions for the
// key signature note number block. No dependencies.
`timescale 1ns / 1ps

package ksnn_pkg;

  // request operation codes (code 3 has no meaning)
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_SET     = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_t;

  // accidental codes (6 and 7 have no meaning)
  typedef enum logic [2:0] {
    ACC_NONE    = 3'd0,
    ACC_SHARP   = 3'd1,
    ACC_DSHARP  = 3'd2,
    ACC_FLAT    = 3'd3,
    ACC_DFLAT   = 3'd4,
    ACC_NATURAL = 3'd5
  } acc_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY_TONIC   = 2'd0,
    CFG_TONIC_SHARP = 2'd1,
    CFG_TONIC_FLAT  = 2'd2,
    CFG_KEY_MODE    = 2'd3
  } cfg_idx_t;

  // mode codes, 10..15 behave as explicit
  typedef enum logic [3:0] {
    MODE_MAJOR      = 4'd0,
    MODE_MINOR      = 4'd1,
    MODE_IONIAN     = 4'd2,
    MODE_AEOLIAN    = 4'd3,
    MODE_MIXOLYDIAN = 4'd4,
    MODE_DORIAN     = 4'd5,
    MODE_PHRYGIAN   = 4'd6,
    MODE_LYDIAN     = 4'd7,
    MODE_LOCRIAN    = 4'd8,
    MODE_EXPLICIT   = 4'd9
  } mode_t;

  localparam int NUM_LETTERS  = 7;
  localparam int LETTER_W     = 3;
  localparam int SIG_W        = 4;
  localparam int NOTE_W       = 9;

  localparam logic signed [5:0] TONIC_SHIFT = 6'sd7;
  localparam logic signed [5:0] SIG_MAX     = 6'sd7;
  localparam logic signed [5:0] SIG_MIN     = -6'sd7;
  localparam logic signed [5:0] SIG_WRAP    = 6'sd12;

  // letter code 7 folds to C
  function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] l);
    fold_letter = (l == 3'd7) ? 3'd0 : l;
  endfunction

  // place on the circle of fifths, C G D A E B with F at -1
  function automatic logic signed [3:0] fifths_pos(input logic [LETTER_W-1:0] l);
    case (l)
      3'd1:    fifths_pos = 4'sd2;
      3'd2:    fifths_pos = 4'sd4;
      3'd3:    fifths_pos = -4'sd1;
      3'd4:    fifths_pos = 4'sd1;
      3'd5:    fifths_pos = 4'sd3;
      3'd6:    fifths_pos = 4'sd5;
      default: fifths_pos = 4'sd0;
    endcase
  endfunction

  function automatic logic signed [3:0] mode_shift(input logic [3:0] m);
    case (m)
      MODE_MINOR, MODE_AEOLIAN: mode_shift = -4'sd3;
      MODE_MIXOLYDIAN:          mode_shift = -4'sd1;
      MODE_DORIAN:              mode_shift = -4'sd2;
      MODE_PHRYGIAN:            mode_shift = -4'sd4;
      MODE_LYDIAN:              mode_shift = 4'sd1;
      MODE_LOCRIAN:             mode_shift = -4'sd5;
      default:                  mode_shift = 4'sd0;
    endcase
  endfunction

  function automatic logic [3:0] natural_semi(input logic [LETTER_W-1:0] l);
    case (l)
      3'd1:    natural_semi = 4'd2;
      3'd2:    natural_semi = 4'd4;
      3'd3:    natural_semi = 4'd5;
      3'd4:    natural_semi = 4'd7;
      3'd5:    natural_semi = 4'd9;
      3'd6:    natural_semi = 4'd11;
      default: natural_semi = 4'd0;
    endcase
  endfunction

  // position of a letter in the order sharps are added: F C G D A E B
  function automatic logic [2:0] sharp_rank(input logic [LETTER_W-1:0] l);
    case (l)
      3'd0:    sharp_rank = 3'd1;
      3'd1:    sharp_rank = 3'd3;
      3'd2:    sharp_rank = 3'd5;
      3'd3:    sharp_rank = 3'd0;
      3'd4:    sharp_rank = 3'd2;
      3'd5:    sharp_rank = 3'd4;
      default: sharp_rank = 3'd6;
    endcase
  endfunction

  // position in the order flats are added: B E A D G C F
  function automatic logic [2:0] flat_rank(input logic [LETTER_W-1:0] l);
    case (l)
      3'd0:    flat_rank = 3'd5;
      3'd1:    flat_rank = 3'd3;
      3'd2:    flat_rank = 3'd1;
      3'd3:    flat_rank = 3'd6;
      3'd4:    flat_rank = 3'd4;
      3'd5:    flat_rank = 3'd2;
      default: flat_rank = 3'd0;
    endcase
  endfunction

  // semitone offset of an explicit accidental, zero for natural and unused codes
  function automatic logic signed [2:0] acc_offset(input logic [2:0] a);
    case (a)
      ACC_SHARP:  acc_offset = 3'sd1;
      ACC_DSHARP: acc_offset = 3'sd2;
      ACC_FLAT:   acc_offset = -3'sd1;
      ACC_DFLAT:  acc_offset = -3'sd2;
      default:    acc_offset = 3'sd0;
    endcase
  endfunction

endpackage

### rtl/core/key_signature_note_number.sv
// key_signature_note_number: key table and MIDI note number lookup.
// Depends on ksnn_pkg for codes and constant tables.
//
//  channel  ports                                             direction  accept
//  request  start, busy, in_operation, in_note_letter,        in         start && !busy
//           in_accidental_code, in_octave
//  result   out_valid, out_note_number, out_key_sharps_flats, out        out_valid
//           out_key_is_minor
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data         in         cfg_valid && cfg_ready
//
// One request per cycle; busy is always low and cfg_ready always high.
// A request is registered in the request register when it is accepted, and its result
// is then registered in the result register, which drives out_valid.
// The key table, signature count and minor flag change at the result edge.
// Synchronous active-low reset clears the key, the table and all strobes.
// The result receiver cannot stall; each strobe lasts exactly one cycle.
`timescale 1ns / 1ps

module key_signature_note_number (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_operation,
  input  logic [ksnn_pkg::LETTER_W-1:0]      in_note_letter,
  input  logic [2:0]                         in_accidental_code,
  input  logic signed [4:0]                  in_octave,
  output logic                               out_valid,
  output logic signed [ksnn_pkg::NOTE_W-1:0] out_note_number,
  output logic signed [ksnn_pkg::SIG_W-1:0]  out_key_sharps_flats,
  output logic                               out_key_is_minor,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [3:0]                         cfg_data
);

  import ksnn_pkg::*;

  // configuration
  logic [LETTER_W-1:0] key_tonic_r;
  logic                tonic_sharp_r;
  logic                tonic_flat_r;
  logic [3:0]          key_mode_r;

  // request register
  logic                s1_valid_r;
  logic [1:0]          s1_op_r;
  logic [LETTER_W-1:0] s1_letter_r;
  logic [2:0]          s1_acc_r;
  logic signed [4:0]   s1_oct_r;

  // key state
  logic signed [2:0]       acc_tbl_r [NUM_LETTERS];
  logic signed [2:0]       acc_tbl_nxt [NUM_LETTERS];
  logic signed [SIG_W-1:0] sig_r, sig_nxt;
  logic                    minor_r, minor_nxt;

  // result register
  logic                     out_valid_r;
  logic signed [NOTE_W-1:0] note_r, note_nxt;

  // restart datapath
  logic signed [5:0] tonic_adj;
  logic signed [5:0] sf_sum;
  logic signed [5:0] sf_wrap;
  logic signed [5:0] sf_mag;
  logic [2:0]        fill_n;

  // lookup datapath
  logic [LETTER_W-1:0] letter;
  logic signed [2:0]   look_off;
  logic signed [5:0]   oct_p2;
  logic signed [9:0]   oct_p2_w;
  logic signed [9:0]   note_w;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_tonic_r   <= '0;
      tonic_sharp_r <= 1'b0;
      tonic_flat_r  <= 1'b0;
      key_mode_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_TONIC:   key_tonic_r   <= cfg_data[LETTER_W-1:0];
        CFG_TONIC_SHARP: tonic_sharp_r <= cfg_data[0];
        CFG_TONIC_FLAT:  tonic_flat_r  <= cfg_data[0];
        CFG_KEY_MODE:    key_mode_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_op_r     <= in_operation;
      s1_letter_r <= in_note_letter;
      s1_acc_r    <= in_accidental_code;
      s1_oct_r    <= in_octave;
    end
  end

  // signature count from tonic, tonic accidental and mode, folded into -7..7
  always_comb begin
    if (tonic_sharp_r) begin
      tonic_adj = TONIC_SHIFT;
    end else if (tonic_flat_r) begin
      tonic_adj = -TONIC_SHIFT;
    end else begin
      tonic_adj = 6'sd0;
    end
    sf_sum = 6'(fifths_pos(fold_letter(key_tonic_r))) + tonic_adj
           + 6'(mode_shift(key_mode_r));
    if (sf_sum < SIG_MIN) begin
      sf_wrap = sf_sum + SIG_WRAP;
    end else if (sf_sum > SIG_MAX) begin
      sf_wrap = sf_sum - SIG_WRAP;
    end else begin
      sf_wrap = sf_sum;
    end
    sf_mag = sf_wrap[5] ? -sf_wrap : sf_wrap;
    fill_n = sf_mag[2:0];
  end

  // note number: natural semitone + accidental + (octave + 2) * 12
  always_comb begin
    letter   = fold_letter(s1_letter_r);
    look_off = (s1_acc_r == ACC_NONE) ? acc_tbl_r[letter] : acc_offset(s1_acc_r);
    oct_p2   = 6'(s1_oct_r) + 6'sd2;
    oct_p2_w = 10'(oct_p2);
    note_w   = $signed({6'd0, natural_semi(letter)}) + 10'(look_off)
             + (oct_p2_w <<< 3) + (oct_p2_w <<< 2);
  end

  always_comb begin
    acc_tbl_nxt = acc_tbl_r;
    sig_nxt     = sig_r;
    minor_nxt   = minor_r;
    note_nxt    = '0;
    if (s1_valid_r) begin
      unique case (s1_op_r)
        OP_RESTART: begin
          sig_nxt   = sf_wrap[SIG_W-1:0];
          minor_nxt = (key_mode_r == MODE_MINOR);
          for (int i = 0; i < NUM_LETTERS; i++) begin
            if (!sf_wrap[5] && sf_wrap != 6'sd0 && sharp_rank(LETTER_W'(i)) < fill_n) begin
              acc_tbl_nxt[i] = 3'sd1;
            end else if (sf_wrap[5] && flat_rank(LETTER_W'(i)) < fill_n) begin
              acc_tbl_nxt[i] = -3'sd1;
            end else begin
              acc_tbl_nxt[i] = 3'sd0;
            end
          end
        end
        OP_SET: begin
          // unused accidental codes leave the table alone
          if (s1_acc_r != ACC_NONE && s1_acc_r <= ACC_NATURAL) begin
            acc_tbl_nxt[letter] = acc_offset(s1_acc_r);
          end
        end
        OP_LOOKUP: begin
          note_nxt = note_w[NOTE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sig_r       <= '0;
      minor_r     <= 1'b0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        acc_tbl_r[i] <= '0;
      end
    end else begin
      out_valid_r <= s1_valid_r;
      sig_r       <= sig_nxt;
      minor_r     <= minor_nxt;
      acc_tbl_r   <= acc_tbl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    note_r <= note_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_note_number      = note_r;
  assign out_key_sharps_flats = sig_r;
  assign out_key_is_minor     = minor_r;

  // every accepted request yields exactly one result, via the request and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted request produced no result");

  // signature count never leaves -7..7
  a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
    sig_r != 4'b1000)
    else $error("signature count out of range");

  // only lookups carry a nonzero note number
  a_non_lookup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_op_r != OP_LOOKUP) |=> (out_note_number == '0))
    else $error("non-lookup result has a note number");

  // minor flag after restart reflects the minor mode code only
  a_minor_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_op_r == OP_RESTART) |=>
      (out_key_is_minor == ($past(key_mode_r) == MODE_MINOR)))
    else $error("minor flag does not match mode");

  // key state only moves on a processed request
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |=> ($stable(sig_r) && $stable(minor_r)))
    else $error("key state changed without a request");

endmodule
